@@ rtl/sia_pkg.sv @@
package sia_pkg;

  // strip length default
  localparam int unsigned LED_COUNT_DEF = 32;

  // configuration port widths
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_DELAY = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_LIT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEP  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_DARK  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_CYCLES = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR      = 3'd6;

  // configuration reset values
  localparam logic [7:0]  STEP_DELAY_RST = 8'd10;
  localparam logic [15:0] HOLD_LIT_RST   = 16'd150;
  localparam logic [7:0]  FADE_STEP_RST  = 8'd10;
  localparam logic [15:0] HOLD_DARK_RST  = 16'd200;
  localparam logic [7:0]  MIN_CYCLES_RST = 8'd3;
  localparam logic [7:0]  INTERVAL_RST   = 8'd5;
  localparam logic [23:0] COLOR_RST      = 24'hFF6400;

  // animation phase, also the reported phase code
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LIGHT = 3'd1,
    PH_HOLD  = 3'd2,
    PH_FADE  = 3'd3,
    PH_DARK  = 3'd4
  } phase_t;

  // configuration register file
  typedef struct packed {
    logic [7:0]  step_delay_ms;
    logic [15:0] hold_lit_ms;
    logic [7:0]  fade_step;
    logic [15:0] hold_dark_ms;
    logic [7:0]  minimum_cycles;
    logic [7:0]  logic_interval_ms;
    logic [23:0] color_rgb;
  } cfg_t;

  // one tick's strip view between sequencer and shading stage
  typedef struct packed {
    logic [5:0] lit;
    phase_t     phase;
    logic [7:0] fade;
  } tick_t;

  // gamma 2.2 entry: largest g with g^5 * 255^6 <= v^11, evaluated at elaboration
  function automatic logic [7:0] gamma_entry(input int unsigned v);
    logic [127:0] target;
    logic [127:0] trial;
    logic [7:0]   g;
    target = 128'd1;
    g      = 8'd0;
    for (int k = 0; k < 11; k++) begin
      target = target * 128'(v);
    end
    for (int unsigned c = 1; c < 256; c++) begin
      trial = 128'd1;
      for (int k = 0; k < 5; k++) begin
        trial = trial * 128'(c);
      end
      for (int k = 0; k < 6; k++) begin
        trial = trial * 128'd255;
      end
      if (trial <= target) begin
        g = 8'(c);
      end
    end
    return g;
  endfunction

endpackage

@@ rtl/sia_in_if.sv @@
interface sia_in_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

@@ rtl/sia_out_if.sv @@
interface sia_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] lit_count;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [2:0] phase;

  modport source (output valid, output lit_count, output red, output green, output blue,
                  output phase, input ready);
  modport sink (input valid, input lit_count, input red, input green, input blue,
                input phase, output ready);
endinterface

@@ rtl/sia_cfg_if.sv @@
interface sia_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sia_pkg::CFG_ADDR_W-1:0] index;
  logic [sia_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sia_seq.sv @@
module sia_seq #(
  parameter int unsigned LED_COUNT = sia_pkg::LED_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  sia_pkg::cfg_t   cfg,
  input  logic            take,
  input  logic            pressed,
  input  logic            drain,
  output logic            tick_valid,
  output sia_pkg::tick_t  tick
);

  localparam logic [5:0] LED_LAST = 6'(LED_COUNT);

  sia_pkg::phase_t mode, mode_next;
  logic [5:0]  next_led, next_led_next;
  logic [7:0]  cycle_count, cycle_count_next;
  logic        held_flag, held_flag_next;
  logic        previous_level, previous_level_next;
  logic        cleared_flag, cleared_flag_next;
  logic [7:0]  fade_level, fade_level_next;
  logic [15:0] since_update, since_update_next;
  logic [15:0] phase_elapsed, phase_elapsed_next;
  sia_pkg::tick_t tick_next;

  // per-tick state update
  always_comb begin
    mode_next           = mode;
    next_led_next       = next_led;
    cycle_count_next    = cycle_count;
    held_flag_next      = held_flag;
    cleared_flag_next   = cleared_flag;
    fade_level_next     = fade_level;
    since_update_next   = (since_update != '1) ? since_update + 16'd1 : since_update;
    phase_elapsed_next  = (phase_elapsed != '1) ? phase_elapsed + 16'd1 : phase_elapsed;

    // press edge starts a run from idle
    if (!previous_level && pressed) begin
      if (mode == sia_pkg::PH_IDLE) begin
        next_led_next      = 6'd0;
        mode_next          = sia_pkg::PH_LIGHT;
        cycle_count_next   = 8'd0;
        cleared_flag_next  = 1'b0;
        phase_elapsed_next = 16'd0;
      end
      held_flag_next = 1'b1;
    end
    if (previous_level && !pressed) begin
      held_flag_next = 1'b0;
    end
    previous_level_next = pressed;

    if (mode_next != sia_pkg::PH_IDLE) begin
      // throttled animation update
      if (since_update_next > {8'd0, cfg.logic_interval_ms}) begin
        since_update_next = 16'd0;
        case (mode_next)
          sia_pkg::PH_LIGHT: begin
            if (phase_elapsed_next >= {8'd0, cfg.step_delay_ms}) begin
              phase_elapsed_next = 16'd0;
              next_led_next      = next_led_next + 6'd1;
              if (next_led_next >= LED_LAST) begin
                mode_next = sia_pkg::PH_HOLD;
              end
            end
          end
          sia_pkg::PH_HOLD: begin
            if (phase_elapsed_next >= cfg.hold_lit_ms) begin
              mode_next       = sia_pkg::PH_FADE;
              fade_level_next = 8'd255;
            end
          end
          sia_pkg::PH_FADE: begin
            if (fade_level_next != 8'd0) begin
              fade_level_next = (fade_level_next > cfg.fade_step) ?
                                fade_level_next - cfg.fade_step : 8'd0;
            end else begin
              mode_next          = sia_pkg::PH_DARK;
              phase_elapsed_next = 16'd0;
            end
          end
          sia_pkg::PH_DARK: begin
            if (phase_elapsed_next >= cfg.hold_dark_ms) begin
              if (cycle_count_next != 8'd255) begin
                cycle_count_next = cycle_count_next + 8'd1;
              end
              if (cycle_count_next < cfg.minimum_cycles || held_flag_next) begin
                mode_next          = sia_pkg::PH_LIGHT;
                next_led_next      = 6'd0;
                phase_elapsed_next = 16'd0;
              end else begin
                mode_next = sia_pkg::PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else if (!cleared_flag_next) begin
      // one-time clear after reset or after a run ends
      next_led_next      = 6'd0;
      since_update_next  = '1;
      phase_elapsed_next = 16'd0;
      fade_level_next    = 8'd255;
      cleared_flag_next  = 1'b1;
    end

    // strip view for this tick
    tick_next.phase = mode_next;
    tick_next.fade  = fade_level_next;
    case (mode_next)
      sia_pkg::PH_LIGHT: tick_next.lit = next_led_next;
      sia_pkg::PH_HOLD:  tick_next.lit = LED_LAST;
      sia_pkg::PH_FADE:  tick_next.lit = LED_LAST;
      default:           tick_next.lit = 6'd0;
    endcase
  end

  // state and first pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= sia_pkg::PH_IDLE;
      next_led       <= 6'd0;
      cycle_count    <= 8'd0;
      held_flag      <= 1'b0;
      previous_level <= 1'b0;
      cleared_flag   <= 1'b0;
      fade_level     <= 8'd255;
      since_update   <= '1;
      phase_elapsed  <= 16'd0;
      tick_valid     <= 1'b0;
    end else begin
      if (take) begin
        mode           <= mode_next;
        next_led       <= next_led_next;
        cycle_count    <= cycle_count_next;
        held_flag      <= held_flag_next;
        previous_level <= previous_level_next;
        cleared_flag   <= cleared_flag_next;
        fade_level     <= fade_level_next;
        since_update   <= since_update_next;
        phase_elapsed  <= phase_elapsed_next;
        tick           <= tick_next;
        tick_valid     <= 1'b1;
      end else if (drain) begin
        tick_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // outside idle the clear flag is always low, so a clear is pending
  a_run_not_cleared: assert property (@(posedge clk) disable iff (rst)
    (mode != sia_pkg::PH_IDLE) |-> cleared_flag == 1'b0)
    else $error("sia_seq: clear flag inconsistent");
  // the lighting counter never runs past the strip
  a_led_bound: assert property (@(posedge clk) disable iff (rst)
    (mode == sia_pkg::PH_LIGHT) |-> next_led < LED_LAST)
    else $error("sia_seq: next_led past strip end in lighting phase");
  // a taken press edge from idle enters lighting, or hold if the strip is passed at once
  a_start: assert property (@(posedge clk) disable iff (rst)
    (take && mode == sia_pkg::PH_IDLE && !previous_level && pressed)
      |=> mode == sia_pkg::PH_LIGHT || mode == sia_pkg::PH_HOLD)
    else $error("sia_seq: press edge did not start the run");
`endif

endmodule

@@ rtl/sia_shade.sv @@
module sia_shade (
  input  sia_pkg::tick_t tick,
  input  logic [23:0]    color_rgb,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue
);

  logic [7:0]  gamma_rom [256];
  logic [7:0]  bright;
  logic [15:0] prod_r, prod_g, prod_b;

  // gamma 2.2 table, constant
  for (genvar gi = 0; gi < 256; gi++) begin : g_rom
    assign gamma_rom[gi] = sia_pkg::gamma_entry(gi);
  end

  // full brightness except while fading
  assign bright = (tick.phase == sia_pkg::PH_FADE) ? gamma_rom[tick.fade] : 8'd255;

  assign prod_r = {8'd0, color_rgb[23:16]} * {8'd0, bright};
  assign prod_g = {8'd0, color_rgb[15:8]} * {8'd0, bright};
  assign prod_b = {8'd0, color_rgb[7:0]} * {8'd0, bright};

  // floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // black strip when nothing is lit
  always_comb begin
    if (tick.lit == 6'd0) begin
      red   = 8'd0;
      green = 8'd0;
      blue  = 8'd0;
    end else begin
      red   = div255(prod_r);
      green = div255(prod_g);
      blue  = div255(prod_b);
    end
  end

endmodule

@@ rtl/sequential_indicator_animator.sv @@
// channel  dir  beat contents
// -------  ---  ----------------------------------------------
// req      in   pressed: indicator level for one 1 ms tick
// res      out  lit_count, red, green, blue, phase for that tick
// cfg      in   index (0..6), data: register write, always ready
//
// One tick per clock is accepted while req.ready is high; each gives exactly one result.
// Stage one updates the animation state, stage two looks up gamma and scales the color.
// The result register is refilled in the cycle it is taken, so stalls cost no throughput.
// A stalled result holds stage one; req.ready drops only when both stages are full.
// rst is synchronous: config returns to defaults, the strip clears on the first tick.
module sequential_indicator_animator #(
  parameter int unsigned LED_COUNT = sia_pkg::LED_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sia_in_if.sink           req,
  sia_out_if.source        res,
  sia_cfg_if.sink          cfg
);

  sia_pkg::cfg_t  cfg_regs;
  sia_pkg::tick_t tick;
  logic           tick_valid;
  logic           take;
  logic           out_load;
  logic [7:0]     red_next, green_next, blue_next;

  // handshake
  assign out_load  = tick_valid && (!res.valid || res.ready);
  assign req.ready = !tick_valid || out_load;
  assign take      = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.step_delay_ms     <= sia_pkg::STEP_DELAY_RST;
      cfg_regs.hold_lit_ms       <= sia_pkg::HOLD_LIT_RST;
      cfg_regs.fade_step         <= sia_pkg::FADE_STEP_RST;
      cfg_regs.hold_dark_ms      <= sia_pkg::HOLD_DARK_RST;
      cfg_regs.minimum_cycles    <= sia_pkg::MIN_CYCLES_RST;
      cfg_regs.logic_interval_ms <= sia_pkg::INTERVAL_RST;
      cfg_regs.color_rgb         <= sia_pkg::COLOR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sia_pkg::REG_STEP_DELAY: cfg_regs.step_delay_ms     <= cfg.data[7:0];
        sia_pkg::REG_HOLD_LIT:   cfg_regs.hold_lit_ms       <= cfg.data[15:0];
        sia_pkg::REG_FADE_STEP:  cfg_regs.fade_step         <= cfg.data[7:0];
        sia_pkg::REG_HOLD_DARK:  cfg_regs.hold_dark_ms      <= cfg.data[15:0];
        sia_pkg::REG_MIN_CYCLES: cfg_regs.minimum_cycles    <= cfg.data[7:0];
        sia_pkg::REG_INTERVAL:   cfg_regs.logic_interval_ms <= cfg.data[7:0];
        sia_pkg::REG_COLOR:      cfg_regs.color_rgb         <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // animation sequencer, stage one
  sia_seq #(
    .LED_COUNT (LED_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .take       (take),
    .pressed    (req.pressed),
    .drain      (out_load),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  // gamma and color scaling
  sia_shade u_shade (
    .tick      (tick),
    .color_rgb (cfg_regs.color_rgb),
    .red       (red_next),
    .green     (green_next),
    .blue      (blue_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.lit_count <= tick.lit;
      res.red       <= red_next;
      res.green     <= green_next;
      res.blue      <= blue_next;
      res.phase     <= tick.phase;
    end
  end

`ifndef SYNTHESIS
  // an unlit strip reports black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.lit_count == 6'd0) |-> (res.red == 8'd0 && res.green == 8'd0 &&
                                              res.blue == 8'd0))
    else $error("sia: color on an unlit strip");
  // idle and dark phases light nothing
  a_dark: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.phase == sia_pkg::PH_IDLE || res.phase == sia_pkg::PH_DARK))
      |-> res.lit_count == 6'd0)
    else $error("sia: LEDs lit in idle or dark phase");
  // never more LEDs than the strip has
  a_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.lit_count <= 6'(LED_COUNT))
    else $error("sia: lit count beyond strip length");
  // a tick is never accepted with both stages full and the result stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && res.valid && !res.ready) |-> !take)
    else $error("sia: tick accepted into a full pipeline");
`endif

endmodule
